// File: src/fanc_pkg.sv
`default_nettype none
package fanc_pkg;

    localparam int DEF_MAX_COLS    = 256;
    localparam int DEF_MAX_ROWS    = 4096;
    localparam int DEF_HEIGHT_BITS = 16;

    localparam int HCODE_W   = 16;
    localparam int LEVEL_W   = 3;
    localparam int OUT_ROW_W = 12;
    localparam int OUT_COL_W = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 13;
    localparam int ROWS_REG_W = 13;
    localparam int COLS_REG_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;

    localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 13'd200;
    localparam logic [COLS_REG_W-1:0] COLS_RESET = 9'd200;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_DRAIN  = 1'b1;

    localparam int NUM_TAPS = 4;
    localparam logic [1:0] X_CTR = 2'd0;
    localparam logic [1:0] X_UP  = 2'd1;
    localparam logic [1:0] X_DN  = 2'd2;
    localparam logic [1:0] X_RT  = 2'd3;

    typedef struct packed {
        logic in_we;
        logic flag_go;
        logic flag_col0;
        logic emit_go;
        logic emit_col0;
        logic emit_last;
    } t_step;

endpackage
`default_nettype wire

// File: src/fanc_in_if.sv
`default_nettype none
interface fanc_in_if;
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic [fanc_pkg::HCODE_W-1:0] height_code;

    modport source (output valid, output op, output height_code, input ready);
    modport sink   (input valid, input op, input height_code, output ready);
endinterface
`default_nettype wire

// File: src/fanc_out_if.sv
`default_nettype none
interface fanc_out_if;
    logic                           valid;
    logic                           ready;
    logic [fanc_pkg::LEVEL_W-1:0]   tree_level;
    logic [fanc_pkg::OUT_ROW_W-1:0] out_row;
    logic [fanc_pkg::OUT_COL_W-1:0] out_col;
    logic                           frame_last;

    modport source (output valid, output tree_level, output out_row, output out_col,
                    output frame_last, input ready);
    modport sink   (input valid, input tree_level, input out_row, input out_col,
                    input frame_last, output ready);
endinterface
`default_nettype wire

// File: src/flat_area_neighbour_count.sv
// A released result passes the emit registers r_a and r_b, then the output register.
// Throughput: one item per cycle; the input stalls only while a finished result sits in the
// last stage and the output register is full and not taken.
// Reset (synchronous, active low): clears all row/column counters and pipeline valids and
// sets the grid to 200 x 200; the line buffer memories are not cleared.
`default_nettype none
module flat_area_neighbour_count #(
    parameter int MAX_COLS    = fanc_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS    = fanc_pkg::DEF_MAX_ROWS,
    parameter int HEIGHT_BITS = fanc_pkg::DEF_HEIGHT_BITS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    fanc_in_if.sink                             i_in,
    fanc_out_if.source                          o_out,
    input  wire logic                           i_cfg_we,
    input  wire logic [fanc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [fanc_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    localparam int RW  = $clog2(MAX_ROWS + 1);
    localparam int CIW = $clog2(MAX_COLS);
    localparam int AW  = $clog2(4 * MAX_COLS);
    localparam int HW  = fanc_pkg::HCODE_W;
    localparam int ORW = fanc_pkg::OUT_ROW_W;
    localparam int OCW = fanc_pkg::OUT_COL_W;
    localparam int LW  = fanc_pkg::LEVEL_W;

    fanc_pkg::t_step        step;
    logic                   en;
    logic                   acc;
    logic [HW+HEIGHT_BITS-1:0] h_ext;
    logic [HEIGHT_BITS-1:0] height;
    logic [AW-1:0]          in_addr;
    logic [AW-1:0]          flag_addr [fanc_pkg::NUM_TAPS];
    logic [AW-1:0]          emit_addr [fanc_pkg::NUM_TAPS];
    logic [RW-1:0]          emit_row;
    logic [CIW-1:0]         emit_col;
    logic                   flat_we;
    logic [AW-1:0]          flat_addr;
    logic                   flat;
    logic                   res_valid;
    logic [LW-1:0]          res_level;
    logic [RW-1:0]          res_row;
    logic [CIW-1:0]         res_col;
    logic                   res_last;
    logic                   r_out_valid;
    logic [LW-1:0]          r_out_level;
    logic [ORW-1:0]         r_out_row;
    logic [OCW-1:0]         r_out_col;
    logic                   r_out_last;

    assign en    = !(res_valid && r_out_valid && !o_out.ready);
    assign acc   = i_in.valid && en;
    assign h_ext = {{HEIGHT_BITS{1'b0}}, i_in.height_code};
    assign height = h_ext[HEIGHT_BITS-1:0];
    assign i_in.ready = en;

    fanc_ctrl #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (acc),
        .i_op        (i_in.op),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_step      (step),
        .o_in_addr   (in_addr),
        .o_flag_addr (flag_addr),
        .o_emit_addr (emit_addr),
        .o_emit_row  (emit_row),
        .o_emit_col  (emit_col)
    );

    fanc_flag #(.MAX_COLS(MAX_COLS), .HEIGHT_BITS(HEIGHT_BITS)) u_flag (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_step      (step),
        .i_in_addr   (in_addr),
        .i_height    (height),
        .i_flag_addr (flag_addr),
        .o_flat_we   (flat_we),
        .o_flat_addr (flat_addr),
        .o_flat      (flat)
    );

    fanc_emit #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_step      (step),
        .i_emit_addr (emit_addr),
        .i_emit_row  (emit_row),
        .i_emit_col  (emit_col),
        .i_flat_we   (flat_we),
        .i_flat_addr (flat_addr),
        .i_flat      (flat),
        .o_res_valid (res_valid),
        .o_level     (res_level),
        .o_row       (res_row),
        .o_col       (res_col),
        .o_last      (res_last)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && res_valid) begin
            r_out_level <= res_level;
            r_out_row   <= ORW'(res_row);
            r_out_col   <= OCW'(res_col);
            r_out_last  <= res_last;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.tree_level = r_out_level;
    assign o_out.out_row    = r_out_row;
    assign o_out.out_col    = r_out_col;
    assign o_out.frame_last = r_out_last;

endmodule
`default_nettype wire

// File: src/fanc_ram.sv
`default_nettype none
module fanc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

endmodule
`default_nettype wire

// File: src/fanc_ctrl.sv
`default_nettype none
module fanc_ctrl #(
    parameter int MAX_COLS = fanc_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = fanc_pkg::DEF_MAX_ROWS,
    localparam int RW  = $clog2(MAX_ROWS + 1),
    localparam int CW  = $clog2(MAX_COLS + 1),
    localparam int CIW = $clog2(MAX_COLS),
    localparam int AW  = $clog2(4 * MAX_COLS)
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_acc,
    input  wire logic                             i_op,
    input  wire logic                             i_cfg_we,
    input  wire logic [fanc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [fanc_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    output fanc_pkg::t_step                       o_step,
    output logic      [AW-1:0]                    o_in_addr,
    output logic      [AW-1:0]                    o_flag_addr [fanc_pkg::NUM_TAPS],
    output logic      [AW-1:0]                    o_emit_addr [fanc_pkg::NUM_TAPS],
    output logic      [RW-1:0]                    o_emit_row,
    output logic      [CIW-1:0]                   o_emit_col
);

    logic [fanc_pkg::ROWS_REG_W-1:0] r_grid_rows;
    logic [fanc_pkg::COLS_REG_W-1:0] r_grid_cols;
    logic [RW-1:0]  r_ir, r_fr, r_er, n_ir, n_fr, n_er;
    logic [CIW-1:0] r_ic, r_fc, r_ec, n_ic, n_fc, n_ec;
    logic [RW-1:0]  rows;
    logic [CW-1:0]  cols;
    logic           cfg_hit;

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
        return AW'(AW'(r[1:0]) * AW'(MAX_COLS) + AW'(c));
    endfunction

    function automatic logic [AW-1:0] cross_addr(input logic [RW-1:0] r, input logic [CW-1:0] c,
                                                 input logic [1:0] k, input logic [RW-1:0] nr,
                                                 input logic [CW-1:0] nc);
        logic [RW-1:0] xr;
        logic [CW-1:0] xc;
        xr = r;
        xc = c;
        case (k)
            fanc_pkg::X_UP: begin
                if (r != '0) xr = r - RW'(1);
            end
            fanc_pkg::X_DN: begin
                if (r + RW'(1) < nr) xr = r + RW'(1);
            end
            fanc_pkg::X_RT: begin
                if (c + CW'(1) < nc) xc = c + CW'(1);
            end
            default: begin
            end
        endcase
        return cell_addr(xr, xc);
    endfunction

    function automatic logic ready_at(input logic [RW-1:0] r, input logic [CW-1:0] c,
                                      input logic [RW-1:0] tr, input logic [CW-1:0] tc,
                                      input logic [RW-1:0] nr, input logic [CW-1:0] nc);
        logic [RW-1:0] qr;
        logic [CW-1:0] qc;
        qr = r;
        qc = c;
        if (r + RW'(1) < nr) begin
            qr = r + RW'(1);
        end else if (c + CW'(1) < nc) begin
            qc = c + CW'(1);
        end
        return (qr < tr) || ((qr == tr) && (qc < tc));
    endfunction

    always_comb begin
        if (r_grid_rows == '0) begin
            rows = RW'(1);
        end else if (32'(r_grid_rows) > 32'(MAX_ROWS)) begin
            rows = RW'(MAX_ROWS);
        end else begin
            rows = RW'(r_grid_rows);
        end
        if (r_grid_cols == '0) begin
            cols = CW'(1);
        end else if (32'(r_grid_cols) > 32'(MAX_COLS)) begin
            cols = CW'(MAX_COLS);
        end else begin
            cols = CW'(r_grid_cols);
        end
    end

    always_comb begin
        o_step = '0;
        n_ir = r_ir;
        n_ic = r_ic;
        n_fr = r_fr;
        n_fc = r_fc;
        n_er = r_er;
        n_ec = r_ec;

        o_step.in_we = i_acc && (i_op == fanc_pkg::OP_SAMPLE) && (r_ir < rows);
        if (o_step.in_we) begin
            if (CW'(r_ic) + CW'(1) >= cols) begin
                n_ic = '0;
                n_ir = r_ir + RW'(1);
            end else begin
                n_ic = r_ic + CIW'(1);
            end
        end

        o_step.flag_go = i_acc && (r_fr < rows)
                       && ready_at(r_fr, CW'(r_fc), n_ir, CW'(n_ic), rows, cols);
        o_step.flag_col0 = (r_fc == '0);
        if (o_step.flag_go) begin
            if (CW'(r_fc) + CW'(1) >= cols) begin
                n_fc = '0;
                n_fr = r_fr + RW'(1);
            end else begin
                n_fc = r_fc + CIW'(1);
            end
        end

        o_step.emit_go = i_acc && (r_er < rows)
                       && ready_at(r_er, CW'(r_ec), n_fr, CW'(n_fc), rows, cols);
        o_step.emit_col0 = (r_ec == '0);
        o_step.emit_last = (r_er + RW'(1) == rows) && (CW'(r_ec) + CW'(1) == cols);
        if (o_step.emit_go) begin
            if (o_step.emit_last) begin
                n_ir = '0;
                n_ic = '0;
                n_fr = '0;
                n_fc = '0;
                n_er = '0;
                n_ec = '0;
            end else if (CW'(r_ec) + CW'(1) >= cols) begin
                n_ec = '0;
                n_er = r_er + RW'(1);
            end else begin
                n_ec = r_ec + CIW'(1);
            end
        end
    end

    always_comb begin
        o_in_addr = cell_addr(r_ir, CW'(r_ic));
        for (int k = 0; k < fanc_pkg::NUM_TAPS; k++) begin
            o_flag_addr[k] = cross_addr(r_fr, CW'(r_fc), 2'(k), rows, cols);
            o_emit_addr[k] = cross_addr(r_er, CW'(r_ec), 2'(k), rows, cols);
        end
        o_emit_row = r_er;
        o_emit_col = r_ec;
    end

    assign cfg_hit = i_cfg_we && ((i_cfg_index == fanc_pkg::CFG_ROWS)
                               || (i_cfg_index == fanc_pkg::CFG_COLS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= fanc_pkg::ROWS_RESET;
            r_grid_cols <= fanc_pkg::COLS_RESET;
            r_ir <= '0;
            r_ic <= '0;
            r_fr <= '0;
            r_fc <= '0;
            r_er <= '0;
            r_ec <= '0;
        end else if (cfg_hit) begin
            if (i_cfg_index == fanc_pkg::CFG_ROWS) begin
                r_grid_rows <= i_cfg_data;
            end else begin
                r_grid_cols <= i_cfg_data[fanc_pkg::COLS_REG_W-1:0];
            end
            r_ir <= '0;
            r_ic <= '0;
            r_fr <= '0;
            r_fc <= '0;
            r_er <= '0;
            r_ec <= '0;
        end else begin
            r_ir <= n_ir;
            r_ic <= n_ic;
            r_fr <= n_fr;
            r_fc <= n_fc;
            r_er <= n_er;
            r_ec <= n_ec;
        end
    end

endmodule
`default_nettype wire

// File: src/fanc_flag.sv
`default_nettype none
module fanc_flag #(
    parameter int MAX_COLS    = fanc_pkg::DEF_MAX_COLS,
    parameter int HEIGHT_BITS = fanc_pkg::DEF_HEIGHT_BITS,
    localparam int AW = $clog2(4 * MAX_COLS)
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire fanc_pkg::t_step        i_step,
    input  wire logic [AW-1:0]          i_in_addr,
    input  wire logic [HEIGHT_BITS-1:0] i_height,
    input  wire logic [AW-1:0]          i_flag_addr [fanc_pkg::NUM_TAPS],
    output logic                        o_flat_we,
    output logic      [AW-1:0]          o_flat_addr,
    output logic                        o_flat
);

    localparam int NT = fanc_pkg::NUM_TAPS;

    logic                   we;
    logic [HEIGHT_BITS-1:0] rd [NT];
    logic [HEIGHT_BITS-1:0] v  [NT];
    logic [HEIGHT_BITS-1:0] left;
    logic                   r_valid;
    logic                   r_col0;
    logic [AW-1:0]          r_addr;
    logic [NT-1:0]          r_hit;
    logic [HEIGHT_BITS-1:0] r_fwd;
    logic [HEIGHT_BITS-1:0] r_prev;

    assign we = i_en && i_step.in_we;

    fanc_ram #(.WIDTH(HEIGHT_BITS), .DEPTH(4 * MAX_COLS)) u_hgt_vert (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (i_in_addr),
        .i_wdata   (i_height),
        .i_re      (i_en),
        .i_raddr_a (i_flag_addr[fanc_pkg::X_UP]),
        .i_raddr_b (i_flag_addr[fanc_pkg::X_DN]),
        .o_rdata_a (rd[fanc_pkg::X_UP]),
        .o_rdata_b (rd[fanc_pkg::X_DN])
    );

    fanc_ram #(.WIDTH(HEIGHT_BITS), .DEPTH(4 * MAX_COLS)) u_hgt_horz (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (i_in_addr),
        .i_wdata   (i_height),
        .i_re      (i_en),
        .i_raddr_a (i_flag_addr[fanc_pkg::X_CTR]),
        .i_raddr_b (i_flag_addr[fanc_pkg::X_RT]),
        .o_rdata_a (rd[fanc_pkg::X_CTR]),
        .o_rdata_b (rd[fanc_pkg::X_RT])
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_step.flag_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_col0 <= i_step.flag_col0;
            r_addr <= i_flag_addr[fanc_pkg::X_CTR];
            r_fwd  <= i_height;
            for (int k = 0; k < NT; k++) begin
                r_hit[k] <= we && (i_in_addr == i_flag_addr[k]);
            end
            if (r_valid) begin
                r_prev <= v[fanc_pkg::X_CTR];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < NT; k++) begin
            v[k] = r_hit[k] ? r_fwd : rd[k];
        end
        left = r_col0 ? v[fanc_pkg::X_CTR] : r_prev;
        o_flat = (v[fanc_pkg::X_UP] == v[fanc_pkg::X_CTR])
              && (v[fanc_pkg::X_DN] == v[fanc_pkg::X_CTR])
              && (v[fanc_pkg::X_RT] == v[fanc_pkg::X_CTR])
              && (left == v[fanc_pkg::X_CTR]);
        o_flat_we   = r_valid;
        o_flat_addr = r_addr;
    end

endmodule
`default_nettype wire

// File: src/fanc_emit.sv
`default_nettype none
module fanc_emit #(
    parameter int MAX_COLS = fanc_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = fanc_pkg::DEF_MAX_ROWS,
    localparam int RW  = $clog2(MAX_ROWS + 1),
    localparam int CIW = $clog2(MAX_COLS),
    localparam int AW  = $clog2(4 * MAX_COLS)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire fanc_pkg::t_step               i_step,
    input  wire logic [AW-1:0]                 i_emit_addr [fanc_pkg::NUM_TAPS],
    input  wire logic [RW-1:0]                 i_emit_row,
    input  wire logic [CIW-1:0]                i_emit_col,
    input  wire logic                          i_flat_we,
    input  wire logic [AW-1:0]                 i_flat_addr,
    input  wire logic                          i_flat,
    output logic                               o_res_valid,
    output logic      [fanc_pkg::LEVEL_W-1:0]  o_level,
    output logic      [RW-1:0]                 o_row,
    output logic      [CIW-1:0]                o_col,
    output logic                               o_last
);

    localparam int NT = fanc_pkg::NUM_TAPS;
    localparam int LW = fanc_pkg::LEVEL_W;

    logic           we;
    logic           rd [NT];
    logic           f  [NT];
    logic           left;
    logic           r_a_valid, r_b_valid;
    logic           r_a_col0, r_b_col0;
    logic           r_a_last, r_b_last;
    logic [RW-1:0]  r_a_row, r_b_row;
    logic [CIW-1:0] r_a_col, r_b_col;
    logic [AW-1:0]  r_a_addr [NT];
    logic [NT-1:0]  r_b_hit;
    logic           r_b_fwd;
    logic           r_prev;

    assign we = i_en && i_flat_we;

    fanc_ram #(.WIDTH(1), .DEPTH(4 * MAX_COLS)) u_flt_vert (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (i_flat_addr),
        .i_wdata   (i_flat),
        .i_re      (i_en),
        .i_raddr_a (r_a_addr[fanc_pkg::X_UP]),
        .i_raddr_b (r_a_addr[fanc_pkg::X_DN]),
        .o_rdata_a (rd[fanc_pkg::X_UP]),
        .o_rdata_b (rd[fanc_pkg::X_DN])
    );

    fanc_ram #(.WIDTH(1), .DEPTH(4 * MAX_COLS)) u_flt_horz (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (i_flat_addr),
        .i_wdata   (i_flat),
        .i_re      (i_en),
        .i_raddr_a (r_a_addr[fanc_pkg::X_CTR]),
        .i_raddr_b (r_a_addr[fanc_pkg::X_RT]),
        .o_rdata_a (rd[fanc_pkg::X_CTR]),
        .o_rdata_b (rd[fanc_pkg::X_RT])
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_step.emit_go;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_col0 <= i_step.emit_col0;
            r_a_last <= i_step.emit_last;
            r_a_row  <= i_emit_row;
            r_a_col  <= i_emit_col;
            r_b_col0 <= r_a_col0;
            r_b_last <= r_a_last;
            r_b_row  <= r_a_row;
            r_b_col  <= r_a_col;
            r_b_fwd  <= i_flat;
            for (int k = 0; k < NT; k++) begin
                r_a_addr[k] <= i_emit_addr[k];
                r_b_hit[k]  <= we && (i_flat_addr == r_a_addr[k]);
            end
            if (r_b_valid) begin
                r_prev <= f[fanc_pkg::X_CTR];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < NT; k++) begin
            f[k] = r_b_hit[k] ? r_b_fwd : rd[k];
        end
        left = r_b_col0 ? f[fanc_pkg::X_CTR] : r_prev;
        o_level = LW'(f[fanc_pkg::X_CTR]) + LW'(f[fanc_pkg::X_UP]) + LW'(f[fanc_pkg::X_DN])
                + LW'(f[fanc_pkg::X_RT]) + LW'(left);
        o_res_valid = r_b_valid;
        o_row  = r_b_row;
        o_col  = r_b_col;
        o_last = r_b_last;
    end

endmodule
`default_nettype wire
